// ----- rtl/wst_pkg.sv -----
// ----------------------------------------------------------------------------
// wst_pkg
// Shared types and constants of the window slot table: operation and status
// codes, request and response payloads, the slot record and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package wst_pkg;

   localparam logic [3:0] OP_CREATE  = 4'd0;
   localparam logic [3:0] OP_COMMIT  = 4'd1;
   localparam logic [3:0] OP_MOVE    = 4'd2;
   localparam logic [3:0] OP_RAISE   = 4'd3;
   localparam logic [3:0] OP_RESIZE  = 4'd4;
   localparam logic [3:0] OP_SENDKEY = 4'd5;
   localparam logic [3:0] OP_GETKEY  = 4'd6;
   localparam logic [3:0] OP_SENDEV  = 4'd7;
   localparam logic [3:0] OP_GETEV   = 4'd8;
   localparam logic [3:0] OP_CLOSE   = 4'd9;
   localparam logic [3:0] OP_REAP    = 4'd10;
   localparam logic [3:0] OP_POLL    = 4'd11;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_INVALID = 3'd1;
   localparam logic [2:0] STAT_DENIED  = 3'd2;
   localparam logic [2:0] STAT_FULL    = 3'd3;
   localparam logic [2:0] STAT_EMPTY   = 3'd4;

   localparam logic signed [31:0] POS_KEEP = 32'sh7FFF_FFFF;
   localparam int LIST_MAX = 16;

   typedef enum logic [1:0] {
      ASEL_SLOT,
      ASEL_IDX,
      ASEL_BEST,
      ASEL_FREE
   } asel_type;

   typedef enum logic [2:0] {
      RK_PLAIN,
      RK_SLOT,
      RK_KEY,
      RK_EV,
      RK_ENTRY
   } rkind_type;

   typedef struct packed {
      logic [3:0]         op;
      logic [31:0]        caller_pid;
      logic               caller_privileged;
      logic [3:0]         slot_id;
      logic [9:0]         width;
      logic [9:0]         height;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [7:0]         key_code;
      logic [15:0]        event_type;
      logic [31:0]        event_args;
      logic [4:0]         poll_limit;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [47:0]        value;
      logic [9:0]         entry_width;
      logic [9:0]         entry_height;
      logic signed [31:0] entry_x;
      logic signed [31:0] entry_y;
      logic [31:0]        entry_stack;
      logic               entry_focused;
      logic [31:0]        entry_generation;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        owner;
      logic [9:0]         width;
      logic [9:0]         height;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [31:0]        stack;
      logic [31:0]        generation;
   } rec_type;

   typedef struct packed {
      logic      load;
      asel_type  asel;
      logic      create;
      logic      exec;
      logic      reap_ck;
      logic      idx_clr;
      logic      idx_inc;
      logic      cnt_clr;
      logic      psel;
      logic      pcmp;
      logic      best_clr;
      logic      rsp_load;
      logic [2:0] rsp_status;
      rkind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       dims_ok;
      logic       id_ok;
      logic       slot_used;
      logic       any_free;
      logic       perm_ok;
      logic       key_empty;
      logic       ev_empty;
      logic       idx_last;
      logic       cnt_zero;
      logic       rsp_done;
   } sts_type;

endpackage

// ----- rtl/wst_if.sv -----
// ----------------------------------------------------------------------------
// wst_if
// Valid/ready channels of the window slot table: request and response.
// ----------------------------------------------------------------------------
interface wst_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         op;
   logic [31:0]        caller_pid;
   logic               caller_privileged;
   logic [3:0]         slot_id;
   logic [9:0]         width;
   logic [9:0]         height;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [7:0]         key_code;
   logic [15:0]        event_type;
   logic [31:0]        event_args;
   logic [4:0]         poll_limit;

   modport source (
      output valid, op, caller_pid, caller_privileged, slot_id, width, height,
             pos_x, pos_y, key_code, event_type, event_args, poll_limit,
      input  ready
   );
   modport sink (
      input  valid, op, caller_pid, caller_privileged, slot_id, width, height,
             pos_x, pos_y, key_code, event_type, event_args, poll_limit,
      output ready
   );
endinterface

interface wst_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [47:0]        value;
   logic [9:0]         entry_width;
   logic [9:0]         entry_height;
   logic signed [31:0] entry_x;
   logic signed [31:0] entry_y;
   logic [31:0]        entry_stack;
   logic               entry_focused;
   logic [31:0]        entry_generation;
   logic               last;

   modport source (
      output valid, status, value, entry_width, entry_height, entry_x, entry_y,
             entry_stack, entry_focused, entry_generation, last,
      input  ready
   );
   modport sink (
      input  valid, status, value, entry_width, entry_height, entry_x, entry_y,
             entry_stack, entry_focused, entry_generation, last,
      output ready
   );
endinterface

// ----- rtl/wst_ram.sv -----
// ----------------------------------------------------------------------------
// wst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/wst_ctrl.sv -----
// ----------------------------------------------------------------------------
// wst_ctrl
// Sequencer of the window slot table: decodes a request, walks the slot
// scans of reap and poll, and hands results to the output register.
// ----------------------------------------------------------------------------
module wst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wst_pkg::sts_type sts,
   output wst_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CREATE,
      ST_PERM,
      ST_RING,
      ST_REAP_RD,
      ST_REAP_CK,
      ST_PSEL,
      ST_PCHK,
      ST_PRD,
      ST_PCMP,
      ST_PGET,
      ST_POUT,
      ST_PRESP,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      cmd            = '0;
      cmd.asel       = wst_pkg::ASEL_SLOT;
      cmd.rsp_status = wst_pkg::STAT_OK;
      cmd.rsp_kind   = wst_pkg::RK_PLAIN;
      state_in       = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ready_ff && req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.op)
               wst_pkg::OP_CREATE: begin
                  if (!sts.dims_ok) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = wst_pkg::STAT_INVALID;
                     state_in       = ST_RESP;
                  end else if (!sts.any_free) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = wst_pkg::STAT_FULL;
                     state_in       = ST_RESP;
                  end else begin
                     cmd.asel = wst_pkg::ASEL_FREE;
                     state_in = ST_CREATE;
                  end
               end
               wst_pkg::OP_REAP: begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_REAP_RD;
               end
               wst_pkg::OP_POLL: begin
                  cmd.idx_clr = 1'b1;
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_PSEL;
               end
               default: begin
                  if (sts.op inside {[4'd12:4'd15]} || !sts.id_ok ||
                      (sts.op == wst_pkg::OP_RESIZE && !sts.dims_ok) ||
                      !sts.slot_used) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = wst_pkg::STAT_INVALID;
                     state_in       = ST_RESP;
                  end else begin
                     state_in = ST_PERM;
                  end
               end
            endcase
         end
         ST_CREATE: begin
            cmd.asel     = wst_pkg::ASEL_FREE;
            cmd.create   = 1'b1;
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = wst_pkg::RK_SLOT;
            state_in     = ST_RESP;
         end
         ST_PERM: begin
            if (!sts.perm_ok) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = wst_pkg::STAT_DENIED;
               state_in       = ST_RESP;
            end else if ((sts.op == wst_pkg::OP_GETKEY && sts.key_empty) ||
                         (sts.op == wst_pkg::OP_GETEV && sts.ev_empty)) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = wst_pkg::STAT_EMPTY;
               state_in       = ST_RESP;
            end else if (sts.op == wst_pkg::OP_GETKEY ||
                         sts.op == wst_pkg::OP_GETEV) begin
               cmd.exec = 1'b1;
               state_in = ST_RING;
            end else begin
               cmd.exec     = 1'b1;
               cmd.rsp_load = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_RING: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = (sts.op == wst_pkg::OP_GETKEY) ? wst_pkg::RK_KEY
                                                          : wst_pkg::RK_EV;
            state_in     = ST_RESP;
         end
         ST_REAP_RD: begin
            cmd.asel = wst_pkg::ASEL_IDX;
            state_in = ST_REAP_CK;
         end
         ST_REAP_CK: begin
            cmd.reap_ck = 1'b1;
            if (sts.idx_last) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_REAP_RD;
            end
         end
         ST_PSEL: begin
            cmd.psel = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_PCHK;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_PCHK: begin
            if (sts.cnt_zero) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = wst_pkg::STAT_EMPTY;
               state_in       = ST_RESP;
            end else begin
               cmd.idx_clr  = 1'b1;
               cmd.best_clr = 1'b1;
               state_in     = ST_PRD;
            end
         end
         ST_PRD: begin
            cmd.asel = wst_pkg::ASEL_IDX;
            state_in = ST_PCMP;
         end
         ST_PCMP: begin
            cmd.pcmp = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_PGET;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_PRD;
            end
         end
         ST_PGET: begin
            cmd.asel = wst_pkg::ASEL_BEST;
            state_in = ST_POUT;
         end
         ST_POUT: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = wst_pkg::RK_ENTRY;
            state_in     = ST_PRESP;
         end
         ST_PRESP: begin
            if (sts.rsp_done) begin
               if (sts.cnt_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_clr  = 1'b1;
                  cmd.best_clr = 1'b1;
                  state_in     = ST_PRD;
               end
            end
         end
         ST_RESP: begin
            if (sts.rsp_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// ----- rtl/wst_dp.sv -----
// ----------------------------------------------------------------------------
// wst_dp
// Datapath of the window slot table: slot flags, ring pointers, the slot
// record RAM, the key and event RAMs, scan index, poll selection and the
// response register.
// ----------------------------------------------------------------------------
module wst_dp #(
   parameter int SLOTS       = 16,
   parameter int KEY_DEPTH   = 32,
   parameter int EVENT_DEPTH = 8,
   parameter int DIM_MAX     = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  wst_pkg::req_type req_data,
   output wst_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  wst_pkg::cmd_type cmd,
   output wst_pkg::sts_type sts
);

   localparam int SW       = $clog2(SLOTS);
   localparam int KPW      = $clog2(KEY_DEPTH);
   localparam int EPW      = $clog2(EVENT_DEPTH);
   localparam int KAW      = $clog2(SLOTS * KEY_DEPTH);
   localparam int EAW      = $clog2(SLOTS * EVENT_DEPTH);
   localparam int LIST_CAP = (SLOTS < wst_pkg::LIST_MAX) ? SLOTS : wst_pkg::LIST_MAX;
   localparam int RECW     = $bits(wst_pkg::rec_type);

   wst_pkg::req_type req_ff;
   wst_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] comm_ff, comm_in;
   logic [SLOTS-1:0] foc_ff, foc_in;
   logic [SLOTS-1:0] genv_ff, genv_in;
   logic [SLOTS-1:0] sel_ff, sel_in;
   logic [SLOTS-1:0] clr;
   logic [KPW-1:0]   khead_ff [SLOTS];
   logic [KPW-1:0]   khead_in [SLOTS];
   logic [KPW-1:0]   ktail_ff [SLOTS];
   logic [KPW-1:0]   ktail_in [SLOTS];
   logic [EPW-1:0]   ehead_ff [SLOTS];
   logic [EPW-1:0]   ehead_in [SLOTS];
   logic [EPW-1:0]   etail_ff [SLOTS];
   logic [EPW-1:0]   etail_in [SLOTS];
   logic [31:0]      stack_ff, stack_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [SW-1:0]    best_ff, best_in;
   logic [31:0]      best_stack_ff, best_stack_in;
   logic             best_valid_ff, best_valid_in;

   logic [SW-1:0]    sid;
   logic [SW-1:0]    free_idx;
   logic [SW-1:0]    rec_addr;
   logic [4:0]       list_max;
   logic [31:0]      gen_cur;
   logic             rec_we;
   logic             key_full, key_empty, ev_full, ev_empty;
   logic             key_we, ev_we;
   logic             owner_only;
   wst_pkg::rec_type rec_rd, rec_wr;
   logic [RECW-1:0]  rec_rd_raw;
   logic [7:0]       key_rd;
   logic [47:0]      ev_rd;
   logic [KAW-1:0]   key_waddr, key_raddr;
   logic [EAW-1:0]   ev_waddr, ev_raddr;

   function automatic logic [KPW-1:0] knext(input logic [KPW-1:0] p);
      return (p == KPW'(KEY_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [EPW-1:0] enext(input logic [EPW-1:0] p);
      return (p == EPW'(EVENT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign sid      = SW'(req_ff.slot_id);
   assign list_max = (req_ff.poll_limit > 5'(LIST_CAP)) ? 5'(LIST_CAP)
                                                        : req_ff.poll_limit;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = SW'(i);
         end
      end
   end

   always_comb begin
      case (cmd.asel)
         wst_pkg::ASEL_IDX:  rec_addr = idx_ff;
         wst_pkg::ASEL_BEST: rec_addr = best_ff;
         wst_pkg::ASEL_FREE: rec_addr = free_idx;
         default:            rec_addr = sid;
      endcase
   end

   assign rec_rd  = wst_pkg::rec_type'(rec_rd_raw);
   assign gen_cur = genv_ff[free_idx] ? rec_rd.generation : 32'd0;

   assign key_empty = (khead_ff[sid] == ktail_ff[sid]);
   assign key_full  = (knext(khead_ff[sid]) == ktail_ff[sid]);
   assign ev_empty  = (ehead_ff[sid] == etail_ff[sid]);
   assign ev_full   = (enext(ehead_ff[sid]) == etail_ff[sid]);

   assign key_waddr = KAW'(sid) * KAW'(KEY_DEPTH) + KAW'(khead_ff[sid]);
   assign key_raddr = KAW'(sid) * KAW'(KEY_DEPTH) + KAW'(ktail_ff[sid]);
   assign ev_waddr  = EAW'(sid) * EAW'(EVENT_DEPTH) + EAW'(ehead_ff[sid]);
   assign ev_raddr  = EAW'(sid) * EAW'(EVENT_DEPTH) + EAW'(etail_ff[sid]);

   assign key_we = cmd.exec && req_ff.op == wst_pkg::OP_SENDKEY && !key_full;
   assign ev_we  = cmd.exec && req_ff.op == wst_pkg::OP_SENDEV && !ev_full;

   assign owner_only = (req_ff.op == wst_pkg::OP_COMMIT) ||
                       (req_ff.op == wst_pkg::OP_RESIZE) ||
                       (req_ff.op == wst_pkg::OP_GETKEY) ||
                       (req_ff.op == wst_pkg::OP_GETEV);

   // record write: fresh record on create, read-modify-write otherwise
   always_comb begin
      rec_wr = rec_rd;
      rec_we = 1'b0;
      if (cmd.create) begin
         rec_we            = 1'b1;
         rec_wr.owner      = req_ff.caller_pid;
         rec_wr.width      = req_ff.width;
         rec_wr.height     = req_ff.height;
         rec_wr.pos_x      = '0;
         rec_wr.pos_y      = '0;
         rec_wr.stack      = stack_ff + 32'd1;
         rec_wr.generation = gen_cur + 32'd1;
      end else if (cmd.exec) begin
         case (req_ff.op)
            wst_pkg::OP_COMMIT: begin
               rec_we = 1'b1;
               if (req_ff.pos_x != wst_pkg::POS_KEEP) begin
                  rec_wr.pos_x = req_ff.pos_x;
                  rec_wr.pos_y = req_ff.pos_y;
               end
            end
            wst_pkg::OP_MOVE: begin
               rec_we       = 1'b1;
               rec_wr.pos_x = req_ff.pos_x;
               rec_wr.pos_y = req_ff.pos_y;
            end
            wst_pkg::OP_RAISE: begin
               rec_we       = 1'b1;
               rec_wr.stack = stack_ff + 32'd1;
            end
            wst_pkg::OP_RESIZE: begin
               rec_we        = 1'b1;
               rec_wr.width  = req_ff.width;
               rec_wr.height = req_ff.height;
            end
            default: begin
               rec_we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      used_in       = used_ff;
      comm_in       = comm_ff;
      foc_in        = foc_ff;
      genv_in       = genv_ff;
      sel_in        = sel_ff;
      khead_in      = khead_ff;
      ktail_in      = ktail_ff;
      ehead_in      = ehead_ff;
      etail_in      = etail_ff;
      stack_in      = stack_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      best_stack_in = best_stack_ff;
      best_valid_in = best_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      clr           = '0;

      if (cmd.create) begin
         clr[free_idx] = 1'b1;
      end
      if (cmd.exec && req_ff.op == wst_pkg::OP_CLOSE) begin
         clr[sid] = 1'b1;
      end
      if (cmd.reap_ck && used_ff[idx_ff] && rec_rd.owner == req_ff.caller_pid) begin
         clr[idx_ff] = 1'b1;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (clr[i]) begin
            used_in[i]  = 1'b0;
            comm_in[i]  = 1'b0;
            foc_in[i]   = 1'b0;
            khead_in[i] = '0;
            ktail_in[i] = '0;
            ehead_in[i] = '0;
            etail_in[i] = '0;
         end
      end

      if (cmd.create) begin
         used_in[free_idx] = 1'b1;
         genv_in[free_idx] = 1'b1;
         stack_in          = stack_ff + 32'd1;
      end

      if (cmd.exec) begin
         case (req_ff.op)
            wst_pkg::OP_COMMIT: begin
               comm_in[sid] = 1'b1;
            end
            wst_pkg::OP_RAISE: begin
               foc_in      = '0;
               foc_in[sid] = 1'b1;
               stack_in    = stack_ff + 32'd1;
            end
            wst_pkg::OP_SENDKEY: begin
               if (!key_full) begin
                  khead_in[sid] = knext(khead_ff[sid]);
               end
            end
            wst_pkg::OP_GETKEY: begin
               if (!key_empty) begin
                  ktail_in[sid] = knext(ktail_ff[sid]);
               end
            end
            wst_pkg::OP_SENDEV: begin
               if (!ev_full) begin
                  ehead_in[sid] = enext(ehead_ff[sid]);
               end
            end
            wst_pkg::OP_GETEV: begin
               if (!ev_empty) begin
                  etail_in[sid] = enext(etail_ff[sid]);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.cnt_clr) begin
         cnt_in = '0;
         sel_in = '0;
      end
      if (cmd.psel && used_ff[idx_ff] && comm_ff[idx_ff] && cnt_ff < list_max) begin
         sel_in[idx_ff] = 1'b1;
         cnt_in         = cnt_ff + 5'd1;
      end

      if (cmd.best_clr) begin
         best_valid_in = 1'b0;
      end
      if (cmd.pcmp && sel_ff[idx_ff] &&
          (!best_valid_ff || rec_rd.stack < best_stack_ff)) begin
         best_in       = idx_ff;
         best_stack_in = rec_rd.stack;
         best_valid_in = 1'b1;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = cmd.rsp_status;
         rsp_in.last   = 1'b1;
         case (cmd.rsp_kind)
            wst_pkg::RK_SLOT: begin
               rsp_in.value = 48'(free_idx);
            end
            wst_pkg::RK_KEY: begin
               rsp_in.value = 48'(key_rd);
            end
            wst_pkg::RK_EV: begin
               rsp_in.value = ev_rd;
            end
            wst_pkg::RK_ENTRY: begin
               rsp_in.value            = 48'(best_ff);
               rsp_in.entry_width      = rec_rd.width;
               rsp_in.entry_height     = rec_rd.height;
               rsp_in.entry_x          = rec_rd.pos_x;
               rsp_in.entry_y          = rec_rd.pos_y;
               rsp_in.entry_stack      = rec_rd.stack;
               rsp_in.entry_focused    = foc_ff[best_ff];
               rsp_in.entry_generation = rec_rd.generation;
               rsp_in.last             = (cnt_ff == 5'd1);
               sel_in[best_ff]         = 1'b0;
               cnt_in                  = cnt_ff - 5'd1;
            end
            default: begin
               rsp_in.value = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         comm_ff       <= '0;
         foc_ff        <= '0;
         genv_ff       <= '0;
         sel_ff        <= '0;
         khead_ff      <= '{default: '0};
         ktail_ff      <= '{default: '0};
         ehead_ff      <= '{default: '0};
         etail_ff      <= '{default: '0};
         stack_ff      <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_ff       <= used_in;
         comm_ff       <= comm_in;
         foc_ff        <= foc_in;
         genv_ff       <= genv_in;
         sel_ff        <= sel_in;
         khead_ff      <= khead_in;
         ktail_ff      <= ktail_in;
         ehead_ff      <= ehead_in;
         etail_ff      <= etail_in;
         stack_ff      <= stack_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      best_ff       <= best_in;
      best_stack_ff <= best_stack_in;
      rsp_ff        <= rsp_in;
   end

   wst_ram #(.WIDTH(RECW), .DEPTH(SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_addr),
      .wr_data (RECW'(rec_wr)),
      .rd_addr (rec_addr),
      .rd_data (rec_rd_raw)
   );

   wst_ram #(.WIDTH(8), .DEPTH(SLOTS * KEY_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (req_ff.key_code),
      .rd_addr (key_raddr),
      .rd_data (key_rd)
   );

   wst_ram #(.WIDTH(48), .DEPTH(SLOTS * EVENT_DEPTH)) u_ev_ram (
      .clock   (clock),
      .wr_en   (ev_we),
      .wr_addr (ev_waddr),
      .wr_data ({req_ff.event_type, req_ff.event_args}),
      .rd_addr (ev_raddr),
      .rd_data (ev_rd)
   );

   assign sts.op        = req_ff.op;
   assign sts.dims_ok   = (req_ff.width != 10'd0) && (req_ff.height != 10'd0) &&
                          (req_ff.width <= 10'(DIM_MAX)) &&
                          (req_ff.height <= 10'(DIM_MAX));
   assign sts.id_ok     = (32'(req_ff.slot_id) < 32'(SLOTS));
   assign sts.slot_used = used_ff[sid];
   assign sts.any_free  = ~&used_ff;
   assign sts.perm_ok   = (rec_rd.owner == req_ff.caller_pid) ||
                          (!owner_only && req_ff.caller_privileged);
   assign sts.key_empty = key_empty;
   assign sts.ev_empty  = ev_empty;
   assign sts.idx_last  = (idx_ff == SW'(SLOTS - 1));
   assign sts.cnt_zero  = (cnt_ff == 5'd0);
   assign sts.rsp_done  = rsp_valid_ff && rsp_ready;

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/window_slot_table_with_mailboxes.sv -----
// ----------------------------------------------------------------------------
// window_slot_table_with_mailboxes
// Window slot table with per-slot key and event rings, built as a sequencer
// and a datapath around a slot record RAM and two ring RAMs.
//
//   channel  direction  carries
//   req_bus  in         one operation and its arguments
//   rsp_bus  out        status and value, or one polled entry per response
//
// Reap reads and checks every slot in turn through the single read port of
// the record RAM; poll first selects the committed slots, then for each
// listed entry scans the selected slots for the lowest stack value and
// sends that entry.
// Synchronous reset clears all flags, ring pointers and the stacking counter.
// A stalled response holds the block; a new request is taken once the last
// response of the previous one is gone.
// ----------------------------------------------------------------------------
module window_slot_table_with_mailboxes #(
   parameter int SLOTS       = 16,
   parameter int KEY_DEPTH   = 32,
   parameter int EVENT_DEPTH = 8,
   parameter int DIM_MAX     = 512
) (
   input logic        clock,
   input logic        reset,
   wst_req_if.sink    req_bus,
   wst_rsp_if.source  rsp_bus
);

   wst_pkg::req_type req_data;
   wst_pkg::rsp_type rsp_data;
   wst_pkg::cmd_type cmd;
   wst_pkg::sts_type sts;
   logic             req_ready;
   logic             rsp_valid;

   assign req_data.op                = req_bus.op;
   assign req_data.caller_pid        = req_bus.caller_pid;
   assign req_data.caller_privileged = req_bus.caller_privileged;
   assign req_data.slot_id           = req_bus.slot_id;
   assign req_data.width             = req_bus.width;
   assign req_data.height            = req_bus.height;
   assign req_data.pos_x             = req_bus.pos_x;
   assign req_data.pos_y             = req_bus.pos_y;
   assign req_data.key_code          = req_bus.key_code;
   assign req_data.event_type        = req_bus.event_type;
   assign req_data.event_args        = req_bus.event_args;
   assign req_data.poll_limit        = req_bus.poll_limit;

   wst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wst_dp #(
      .SLOTS       (SLOTS),
      .KEY_DEPTH   (KEY_DEPTH),
      .EVENT_DEPTH (EVENT_DEPTH),
      .DIM_MAX     (DIM_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign req_bus.ready            = req_ready;
   assign rsp_bus.valid            = rsp_valid;
   assign rsp_bus.status           = rsp_data.status;
   assign rsp_bus.value            = rsp_data.value;
   assign rsp_bus.entry_width      = rsp_data.entry_width;
   assign rsp_bus.entry_height     = rsp_data.entry_height;
   assign rsp_bus.entry_x          = rsp_data.entry_x;
   assign rsp_bus.entry_y          = rsp_data.entry_y;
   assign rsp_bus.entry_stack      = rsp_data.entry_stack;
   assign rsp_bus.entry_focused    = rsp_data.entry_focused;
   assign rsp_bus.entry_generation = rsp_data.entry_generation;
   assign rsp_bus.last             = rsp_data.last;

`ifndef ASSERT_OFF
   // no new request while a response is still pending
   a_req_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_ready) |-> !rsp_valid)
      else $error("request accepted with a response pending");

   // the final response frees the request side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bus.ready && rsp_data.last) |=> req_ready)
      else $error("not ready after the final response");

   // a non-final response only comes from a poll listing
   a_multi_poll: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (sts.op == wst_pkg::OP_POLL &&
                                         rsp_data.status == wst_pkg::STAT_OK))
      else $error("non-final response outside a poll");
`endif

endmodule

// ----- bench/wst_tb_if.sv -----
// ----------------------------------------------------------------------------
// wst_tb_if
// Bench-side handle on the window slot table channels: the request and
// response interfaces come from the RTL; this file pulls the package in and
// sets the bench slot and ring sizes, so that the bench files compile in one ordered list.
// ----------------------------------------------------------------------------
package wst_tb_pkg;
   import wst_pkg::*;
   localparam int TB_SLOTS = 16;
   localparam int TB_KEYS  = 32;
   localparam int TB_EVS   = 8;
endpackage

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the window slot table: a queue-fed driver sends directed and random
// requests under random stalls, a slot table model predicts every response
// and a monitor compares each response field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wst_pkg::*;
   import wst_tb_pkg::*;

   logic clock = 0;
   logic reset = 1;
   always #4 clock = ~clock;

   wst_req_if req_bus();
   wst_rsp_if rsp_bus();

   window_slot_table_with_mailboxes DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus)
   );

   // slot table model
   bit          m_used [TB_SLOTS];
   bit          m_comm [TB_SLOTS];
   bit          m_foc  [TB_SLOTS];
   bit   [31:0] m_owner[TB_SLOTS];
   bit   [9:0]  m_w    [TB_SLOTS];
   bit   [9:0]  m_h    [TB_SLOTS];
   bit   [31:0] m_x    [TB_SLOTS];
   bit   [31:0] m_y    [TB_SLOTS];
   bit   [31:0] m_stack[TB_SLOTS];
   bit   [31:0] m_gen  [TB_SLOTS];
   bit   [31:0] m_top;
   bit   [7:0]  m_keys [TB_SLOTS][TB_KEYS];
   int          m_khead[TB_SLOTS];
   int          m_ktail[TB_SLOTS];
   bit   [47:0] m_evs  [TB_SLOTS][TB_EVS];
   int          m_ehead[TB_SLOTS];
   int          m_etail[TB_SLOTS];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors = 0;
   bit      stim_done = 0;
   bit      rsp_quiet = 0;
   int      long_hold = 0;
   bit      want_long_hold = 0;

   function automatic void clear_slot(int s);
      m_used[s] = 0; m_comm[s] = 0; m_foc[s] = 0; m_owner[s] = 0;
      m_w[s] = 0; m_h[s] = 0; m_x[s] = 0; m_y[s] = 0; m_stack[s] = 0;
      m_khead[s] = 0; m_ktail[s] = 0; m_ehead[s] = 0; m_etail[s] = 0;
   endfunction

   function automatic rsp_type plain_rsp(logic [2:0] st, logic [47:0] v);
      rsp_type r;
      r = '0;
      r.status = st;
      r.value = v;
      r.last = 1;
      return r;
   endfunction

   function automatic bit dims_valid(logic [9:0] w, logic [9:0] h);
      return w != 0 && h != 0 && w <= 512 && h <= 512;
   endfunction

   function automatic void predict_table(req_type q);
      int      s, n, i, j, t, lim, nh;
      int      idx[16];
      bit      owner, only_owner;
      rsp_type r;
      case (q.op)
         OP_CREATE: begin
            if (!dims_valid(q.width, q.height)) begin
               expected_rsps.push_back(plain_rsp(STAT_INVALID, 0));
               return;
            end
            for (s = 0; s < TB_SLOTS; s++) if (!m_used[s]) break;
            if (s >= TB_SLOTS) begin
               expected_rsps.push_back(plain_rsp(STAT_FULL, 0));
               return;
            end
            m_gen[s]++;
            clear_slot(s);
            m_w[s] = q.width; m_h[s] = q.height; m_owner[s] = q.caller_pid;
            m_top++;
            m_stack[s] = m_top;
            m_used[s] = 1;
            expected_rsps.push_back(plain_rsp(STAT_OK, 48'(s)));
            return;
         end
         OP_REAP: begin
            for (s = 0; s < TB_SLOTS; s++)
               if (m_used[s] && m_owner[s] == q.caller_pid) clear_slot(s);
            expected_rsps.push_back(plain_rsp(STAT_OK, 0));
            return;
         end
         OP_POLL: begin
            lim = q.poll_limit > 16 ? 16 : q.poll_limit;
            n = 0;
            for (s = 0; s < TB_SLOTS && n < lim; s++)
               if (m_used[s] && m_comm[s]) begin
                  idx[n] = s;
                  n++;
               end
            if (n == 0) begin
               expected_rsps.push_back(plain_rsp(STAT_EMPTY, 0));
               return;
            end
            for (i = 1; i < n; i++) begin
               t = idx[i];
               j = i;
               while (j > 0 && m_stack[idx[j-1]] > m_stack[t]) begin
                  idx[j] = idx[j-1];
                  j--;
               end
               idx[j] = t;
            end
            for (i = 0; i < n; i++) begin
               s = idx[i];
               r = plain_rsp(STAT_OK, 48'(s));
               r.entry_width = m_w[s];
               r.entry_height = m_h[s];
               r.entry_x = m_x[s];
               r.entry_y = m_y[s];
               r.entry_stack = m_stack[s];
               r.entry_focused = m_foc[s];
               r.entry_generation = m_gen[s];
               r.last = (i + 1 == n);
               expected_rsps.push_back(r);
            end
            return;
         end
         default: ;
      endcase
      if (q.op > OP_POLL) begin
         expected_rsps.push_back(plain_rsp(STAT_INVALID, 0));
         return;
      end
      s = q.slot_id;
      if ((q.op == OP_RESIZE && !dims_valid(q.width, q.height)) || !m_used[s]) begin
         expected_rsps.push_back(plain_rsp(STAT_INVALID, 0));
         return;
      end
      owner = m_owner[s] == q.caller_pid;
      only_owner = q.op inside {OP_COMMIT, OP_RESIZE, OP_GETKEY, OP_GETEV};
      if (!(owner || (!only_owner && q.caller_privileged))) begin
         expected_rsps.push_back(plain_rsp(STAT_DENIED, 0));
         return;
      end
      case (q.op)
         OP_COMMIT: begin
            if (q.pos_x != POS_KEEP) begin
               m_x[s] = q.pos_x; m_y[s] = q.pos_y;
            end
            m_comm[s] = 1;
         end
         OP_MOVE: begin
            m_x[s] = q.pos_x; m_y[s] = q.pos_y;
         end
         OP_RAISE: begin
            for (i = 0; i < TB_SLOTS; i++) m_foc[i] = 0;
            m_top++;
            m_stack[s] = m_top;
            m_foc[s] = 1;
         end
         OP_RESIZE: begin
            m_w[s] = q.width; m_h[s] = q.height;
         end
         OP_SENDKEY: begin
            nh = (m_khead[s] + 1) % TB_KEYS;
            if (nh != m_ktail[s]) begin
               m_keys[s][m_khead[s]] = q.key_code;
               m_khead[s] = nh;
            end
         end
         OP_GETKEY: begin
            if (m_khead[s] == m_ktail[s]) begin
               expected_rsps.push_back(plain_rsp(STAT_EMPTY, 0));
               return;
            end
            t = m_ktail[s];
            m_ktail[s] = (t + 1) % TB_KEYS;
            expected_rsps.push_back(plain_rsp(STAT_OK, 48'(m_keys[s][t])));
            return;
         end
         OP_SENDEV: begin
            nh = (m_ehead[s] + 1) % TB_EVS;
            if (nh != m_etail[s]) begin
               m_evs[s][m_ehead[s]] = {q.event_type, q.event_args};
               m_ehead[s] = nh;
            end
         end
         OP_GETEV: begin
            if (m_ehead[s] == m_etail[s]) begin
               expected_rsps.push_back(plain_rsp(STAT_EMPTY, 0));
               return;
            end
            t = m_etail[s];
            m_etail[s] = (t + 1) % TB_EVS;
            expected_rsps.push_back(plain_rsp(STAT_OK, m_evs[s][t]));
            return;
         end
         default: clear_slot(s);
      endcase
      expected_rsps.push_back(plain_rsp(STAT_OK, 0));
   endfunction

   function automatic req_type make_req(logic [3:0] op, logic [31:0] pid, bit priv,
                                        logic [3:0] id);
      req_type q;
      q.op = op;
      q.caller_pid = pid;
      q.caller_privileged = priv;
      q.slot_id = id;
      q.width = $urandom_range(1, 512);
      q.height = $urandom_range(1, 512);
      q.pos_x = $urandom;
      q.pos_y = $urandom;
      q.key_code = $urandom;
      q.event_type = $urandom;
      q.event_args = $urandom;
      q.poll_limit = $urandom_range(0, 16);
      return q;
   endfunction

   function automatic req_type random_req();
      req_type q;
      int      k;
      k = $urandom_range(0, 99);
      q = make_req($urandom_range(0, 11), $urandom_range(1, 4), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 15));
      if (k < 10) q.op = OP_CREATE;
      if (k < 3) begin
         q.width = $urandom_range(0, 1) ? 0 : $urandom_range(513, 1023);
         q.height = $urandom;
      end
      if (k >= 97) q = '{op: $urandom_range(12, 15), caller_pid: $urandom,
                          caller_privileged: $urandom, slot_id: $urandom,
                          width: $urandom, height: $urandom, pos_x: $urandom,
                          pos_y: $urandom, key_code: $urandom, event_type: $urandom,
                          event_args: $urandom, poll_limit: $urandom};
      if (k >= 94 && k < 97) q.caller_pid = $urandom;
      if (q.op == OP_COMMIT && k < 30) q.pos_x = POS_KEEP;
      if (q.op == OP_POLL && k < 60) q.poll_limit = 16;
      return q;
   endfunction

   // driver
   int  req_gap = 0;
   bit  req_pause = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) predict_table(req_type'({req_bus.op,
            req_bus.caller_pid, req_bus.caller_privileged, req_bus.slot_id,
            req_bus.width, req_bus.height, req_bus.pos_x, req_bus.pos_y,
            req_bus.key_code, req_bus.event_type, req_bus.event_args,
            req_bus.poll_limit}));
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_bus.valid <= 0;
            end else if (pending_reqs.size() > 0 && !req_pause) begin
               req_bus.valid <= 1;
               {req_bus.op, req_bus.caller_pid, req_bus.caller_privileged,
                req_bus.slot_id, req_bus.width, req_bus.height, req_bus.pos_x,
                req_bus.pos_y, req_bus.key_code, req_bus.event_type,
                req_bus.event_args, req_bus.poll_limit} <= pending_reqs.pop_front();
               if (!rsp_quiet && $urandom_range(0, 4) == 0) req_gap <= $urandom_range(1, 6);
            end else begin
               req_bus.valid <= 0;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_bus.ready <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.status, rsp_bus.value, rsp_bus.entry_width,
                   rsp_bus.entry_height, rsp_bus.entry_x, rsp_bus.entry_y,
                   rsp_bus.entry_stack, rsp_bus.entry_focused,
                   rsp_bus.entry_generation, rsp_bus.last};
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t unexpected response %p", $time, got);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status || got.value !== want.value ||
                   got.entry_width !== want.entry_width ||
                   got.entry_height !== want.entry_height ||
                   got.entry_x !== want.entry_x || got.entry_y !== want.entry_y ||
                   got.entry_stack !== want.entry_stack ||
                   got.entry_focused !== want.entry_focused ||
                   got.entry_generation !== want.entry_generation ||
                   got.last !== want.last) begin
                  errors++;
                  $display("%0t mismatch expected %p actual %p", $time, want, got);
               end
            end
         end
         if (want_long_hold && long_hold == 0) long_hold <= 300;
         if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            rsp_bus.ready <= 0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_bus.ready <= 0;
         end else begin
            rsp_bus.ready <= 1;
            if (!rsp_quiet && $urandom_range(0, 4) == 0) rsp_gap <= $urandom_range(1, 6);
         end
      end
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int      i, s;
      req_type q;
      req_bus.valid = 0;
      {req_bus.op, req_bus.caller_pid, req_bus.caller_privileged, req_bus.slot_id,
       req_bus.width, req_bus.height, req_bus.pos_x, req_bus.pos_y,
       req_bus.key_code, req_bus.event_type, req_bus.event_args,
       req_bus.poll_limit} = '0;
      rsp_bus.ready = 0;
      for (s = 0; s < TB_SLOTS; s++) begin
         clear_slot(s);
         m_gen[s] = 0;
      end
      m_top = 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed
      pending_reqs.push_back(make_req(OP_POLL, 1, 0, 0));
      q = make_req(OP_CREATE, 1, 0, 0); q.width = 512; q.height = 1;
      pending_reqs.push_back(q);
      q = make_req(OP_CREATE, 2, 0, 0); q.width = 0; pending_reqs.push_back(q);
      q = make_req(OP_CREATE, 2, 0, 0); q.height = 1023; pending_reqs.push_back(q);
      pending_reqs.push_back(make_req(OP_CREATE, 32'hFFFF_FFFF, 0, 0));
      q = make_req(OP_COMMIT, 1, 0, 0); q.pos_x = 32'h8000_0000; q.pos_y = 32'h7FFF_FFFF;
      pending_reqs.push_back(q);
      q = make_req(OP_COMMIT, 32'hFFFF_FFFF, 0, 1); q.pos_x = POS_KEEP;
      pending_reqs.push_back(q);
      pending_reqs.push_back(make_req(OP_COMMIT, 2, 1, 1));
      pending_reqs.push_back(make_req(OP_MOVE, 2, 1, 1));
      pending_reqs.push_back(make_req(OP_RAISE, 1, 0, 0));
      q = make_req(OP_RESIZE, 1, 0, 0); q.width = 1; q.height = 512;
      pending_reqs.push_back(q);
      q = make_req(OP_RESIZE, 1, 0, 0); q.width = 513; pending_reqs.push_back(q);
      pending_reqs.push_back(make_req(OP_GETKEY, 1, 0, 0));
      for (i = 0; i < 33; i++) pending_reqs.push_back(make_req(OP_SENDKEY, 9, 1, 0));
      pending_reqs.push_back(make_req(OP_GETKEY, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_GETEV, 1, 0, 0));
      for (i = 0; i < 9; i++) pending_reqs.push_back(make_req(OP_SENDEV, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_GETEV, 1, 0, 0));
      pending_reqs.push_back(make_req(OP_CLOSE, 1, 0, 5));
      q = make_req(OP_POLL, 1, 0, 0); q.poll_limit = 16; pending_reqs.push_back(q);
      pending_reqs.push_back(make_req(OP_REAP, 32'hFFFF_FFFF, 0, 0));
      q = make_req(OP_POLL, 1, 0, 0); q.poll_limit = 31; pending_reqs.push_back(q);
      pending_reqs.push_back(make_req(OP_CLOSE, 1, 0, 0));
      q = make_req(4'd15, 32'hFFFF_FFFF, 1, 4'hF); pending_reqs.push_back(q);
      for (i = 0; i < 17; i++) pending_reqs.push_back(make_req(OP_CREATE, 3, 0, 0));
      pending_reqs.push_back(make_req(OP_REAP, 3, 0, 0));
      wait (pending_reqs.size() == 0);

      // random, with a long response hold and a full drain pause
      for (i = 0; i < 100; i++) begin
         pending_reqs.push_back(random_req());
         if (i == 50) begin
            want_long_hold = 1;
            wait (pending_reqs.size() == 0);
            want_long_hold = 0;
            req_pause = 1;
            wait (expected_rsps.size() == 0 && !req_bus.valid);
            req_pause = 0;
         end
         if (i == 80) begin
            wait (pending_reqs.size() == 0);
            rsp_quiet = 1;
         end
      end
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_bus.valid) @(posedge clock);
      wait (expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
